FILE: rtl/core/acrs_pkg.sv
// ----------------------------------------------------------------------------
// acrs_pkg
// Types, constants and helpers shared by the angular clip range set.
// ----------------------------------------------------------------------------
package acrs_pkg;

  localparam int MAX_INTERVALS = 64;
  localparam int ANGLE_BITS    = 16;
  localparam int ANG_W         = 17;
  localparam int OUT_CNT_W     = 7;
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);

  localparam logic [ANG_W-1:0] FULL_ANGLE = ANG_W'(1) << ANGLE_BITS;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_QUERY = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CELL_NOP,
    CELL_MERGE,
    CELL_EXTEND,
    CELL_INSERT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OP,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ANG_W-1:0] from_angle;
    logic [ANG_W-1:0] to_angle;
  } acrs_in_t;

  typedef struct packed {
    logic                 visible;
    logic                 full_res;
    logic                 overflow;
    logic [OUT_CNT_W-1:0] interval_count;
  } acrs_out_t;

  typedef struct packed {
    cell_op_e         op;
    logic [ANG_W-1:0] lo;
    logic [ANG_W-1:0] hi;
  } cell_cmd_t;

  typedef struct packed {
    logic any_hit;
    logic dbl;
    logic cont;
    logic full;
  } chain_flags_t;

  function automatic logic [ANG_W-1:0] sat_angle(input logic [ANG_W-1:0] a);
    return (a > FULL_ANGLE) ? FULL_ANGLE : a;
  endfunction

endpackage

FILE: rtl/core/acrs_cell.sv
// ----------------------------------------------------------------------------
// acrs_cell
// One slot of the sorted interval chain: compares against the broadcast
// interval and shifts, merges or takes a new interval.
// ----------------------------------------------------------------------------
module acrs_cell (
  input  logic                     clk_i,
  input  acrs_pkg::cell_cmd_t      cmd_i,
  input  logic                     valid_i,
  input  logic [acrs_pkg::ANG_W-1:0] prev_start_i,
  input  logic [acrs_pkg::ANG_W-1:0] prev_end_i,
  input  logic                     prev_g_i,
  input  logic [acrs_pkg::ANG_W-1:0] next_start_i,
  input  logic [acrs_pkg::ANG_W-1:0] next_end_i,
  input  logic                     next_hit_i,
  output logic [acrs_pkg::ANG_W-1:0] start_o,
  output logic [acrs_pkg::ANG_W-1:0] end_o,
  output logic                     g_o,
  output logic                     hit_o,
  output logic                     dbl_o,
  output logic                     cont_o
);
  import acrs_pkg::*;

  logic [ANG_W-1:0] start_q, start_d;
  logic [ANG_W-1:0] end_q, end_d;
  logic             end_ge_lo, start_le_hi, lead;

  assign end_ge_lo   = end_q >= cmd_i.lo;
  assign start_le_hi = start_q <= cmd_i.hi;

  // empty slots count as lying past the interval, so g stays monotone
  assign g_o    = !valid_i || end_ge_lo;
  assign hit_o  = valid_i && end_ge_lo && start_le_hi;
  assign lead   = g_o && !prev_g_i;
  assign dbl_o  = lead && hit_o && next_hit_i;
  assign cont_o = valid_i && (start_q <= cmd_i.lo) && (end_q >= cmd_i.hi);

  assign start_o = start_q;
  assign end_o   = end_q;

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    case (cmd_i.op)
      CELL_MERGE: begin
        if (lead) begin
          start_d = (cmd_i.lo < start_q) ? cmd_i.lo : start_q;
          end_d   = next_end_i;
        end else if (prev_g_i) begin
          start_d = next_start_i;
          end_d   = next_end_i;
        end
      end
      CELL_EXTEND: begin
        if (lead) begin
          start_d = (cmd_i.lo < start_q) ? cmd_i.lo : start_q;
          end_d   = (cmd_i.hi > end_q) ? cmd_i.hi : end_q;
        end
      end
      CELL_INSERT: begin
        if (lead) begin
          start_d = cmd_i.lo;
          end_d   = cmd_i.hi;
        end else if (prev_g_i) begin
          start_d = prev_start_i;
          end_d   = prev_end_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

endmodule

FILE: rtl/core/acrs_ctrl.sv
// ----------------------------------------------------------------------------
// acrs_ctrl
// Sequencer: takes transactions, issues cell commands per half interval,
// tracks count and overflow, and holds the result register.
// ----------------------------------------------------------------------------
module acrs_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  acrs_pkg::acrs_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output acrs_pkg::acrs_out_t        out_data_o,
  output acrs_pkg::cell_cmd_t        cmd_o,
  output logic [acrs_pkg::CNT_W-1:0] count_o,
  input  acrs_pkg::chain_flags_t     flags_i
);
  import acrs_pkg::*;

  state_e           state_q, state_d;
  logic [1:0]       mode_q, mode_d;
  logic [ANG_W-1:0] from_q, from_d, to_q, to_d;
  logic             wrap_q, wrap_d, half_q, half_d, vis_q, vis_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic             out_valid_q, out_valid_d;
  acrs_out_t        out_data_q, out_data_d;
  logic             in_take, out_free, out_load, last;
  logic [ANG_W-1:0] sat_from, sat_to;
  cell_op_e         cmd_op;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) || ((state_q == ST_RESP) && out_free));
  assign in_take    = in_valid_i && !in_stall_o;
  assign sat_from   = sat_angle(in_data_i.from_angle);
  assign sat_to     = sat_angle(in_data_i.to_angle);
  assign last       = !wrap_q || half_q;

  always_comb begin
    cmd_o.op = cmd_op;
    if (wrap_q && !half_q) begin
      cmd_o.lo = '0;
      cmd_o.hi = to_q;
    end else if (wrap_q) begin
      cmd_o.lo = from_q;
      cmd_o.hi = FULL_ANGLE;
    end else begin
      cmd_o.lo = from_q;
      cmd_o.hi = to_q;
    end
  end

  always_comb begin
    state_d  = state_q;
    half_d   = half_q;
    vis_d    = vis_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    out_load = 1'b0;
    cmd_op   = CELL_NOP;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_OP;
      end
      ST_OP: begin
        case (mode_q)
          MODE_ADD: begin
            if (flags_i.dbl) begin
              cmd_op  = CELL_MERGE;
              count_d = count_q - CNT_W'(1);
            end else begin
              if (flags_i.any_hit) begin
                cmd_op = CELL_EXTEND;
              end else if (count_q < CNT_W'(MAX_INTERVALS)) begin
                cmd_op  = CELL_INSERT;
                count_d = count_q + CNT_W'(1);
              end else begin
                ovf_d = 1'b1;
              end
              if (last) state_d = ST_RESP;
              else      half_d  = 1'b1;
            end
          end
          MODE_QUERY: begin
            vis_d = half_q ? (vis_q || !flags_i.cont) : !flags_i.cont;
            if (last) state_d = ST_RESP;
            else      half_d  = 1'b1;
          end
          MODE_CLEAR: begin
            count_d = '0;
            state_d = ST_RESP;
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = in_valid_i ? ST_OP : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (in_take) begin
      half_d = 1'b0;
      vis_d  = 1'b1;
    end
  end

  always_comb begin
    mode_d = mode_q;
    from_d = from_q;
    to_d   = to_q;
    wrap_d = wrap_q;
    if (in_take) begin
      mode_d = in_data_i.mode;
      from_d = sat_from;
      to_d   = sat_to;
      wrap_d = sat_from > sat_to;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d               = 1'b1;
      out_data_d.visible        = vis_q;
      out_data_d.full_res       = flags_i.full;
      out_data_d.overflow       = ovf_q;
      out_data_d.interval_count = OUT_CNT_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      half_q      <= 1'b0;
      vis_q       <= 1'b1;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      half_q      <= half_d;
      vis_q       <= vis_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    from_q     <= from_d;
    to_q       <= to_d;
    wrap_q     <= wrap_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign count_o     = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_INTERVALS))
    else $error("stored count above capacity");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == CELL_INSERT) |-> (count_q < CNT_W'(MAX_INTERVALS)))
    else $error("insert issued on a full chain");

  a_merge_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == CELL_MERGE) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("merge did not drop one entry");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag cleared");

endmodule

FILE: rtl/core/angular_clip_range_set.sv
// ----------------------------------------------------------------------------
// angular_clip_range_set
// Sorted set of disjoint angle intervals held in a chain of cells.
// ----------------------------------------------------------------------------
// Flow: accept, operate (once per half of a wrapped item, again per neighbor
//   absorbed by a merge), then respond once the output is free. New input is
//   taken only while idle or in the respond step as a result is loaded.
// Reset: asynchronous, empties the set and clears the overflow flag; the
//   interval slots themselves are not reset.
module angular_clip_range_set (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  acrs_pkg::acrs_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acrs_pkg::acrs_out_t out_data_o
);
  import acrs_pkg::*;

  cell_cmd_t        cmd;
  chain_flags_t     flags;
  logic [CNT_W-1:0] count;

  logic [ANG_W-1:0] start_w [MAX_INTERVALS];
  logic [ANG_W-1:0] end_w   [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] valid_w, g_w, hit_w, dbl_w, cont_w;

  acrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_o       (cmd),
    .count_o     (count),
    .flags_i     (flags)
  );

  for (genvar j = 0; j < MAX_INTERVALS; j++) begin : g_cell
    logic [ANG_W-1:0] p_start, p_end, n_start, n_end;
    logic             p_g, n_hit;

    assign valid_w[j] = count > CNT_W'(j);

    if (j == 0) begin : g_first
      assign p_start = '0;
      assign p_end   = '0;
      assign p_g     = 1'b0;
    end else begin : g_mid_lo
      assign p_start = start_w[j-1];
      assign p_end   = end_w[j-1];
      assign p_g     = g_w[j-1];
    end

    if (j == MAX_INTERVALS - 1) begin : g_last
      assign n_start = '0;
      assign n_end   = '0;
      assign n_hit   = 1'b0;
    end else begin : g_mid_hi
      assign n_start = start_w[j+1];
      assign n_end   = end_w[j+1];
      assign n_hit   = hit_w[j+1];
    end

    acrs_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .valid_i      (valid_w[j]),
      .prev_start_i (p_start),
      .prev_end_i   (p_end),
      .prev_g_i     (p_g),
      .next_start_i (n_start),
      .next_end_i   (n_end),
      .next_hit_i   (n_hit),
      .start_o      (start_w[j]),
      .end_o        (end_w[j]),
      .g_o          (g_w[j]),
      .hit_o        (hit_w[j]),
      .dbl_o        (dbl_w[j]),
      .cont_o       (cont_w[j])
    );
  end

  assign flags.any_hit = |hit_w;
  assign flags.dbl     = |dbl_w;
  assign flags.cont    = |cont_w;
  assign flags.full    = valid_w[0] && (start_w[0] == '0) && (end_w[0] == FULL_ANGLE);

endmodule

FILE: dv/angular_clip_range_set_tb.sv
// ----------------------------------------------------------------------------
// angular_clip_range_set_tb
// Self-checking bench for the angular clip range set. Adds, queries and
// clears (directed corner cases, then random episodes that fill the store,
// merge ranges, cover the full circle, or throw noise) go through a
// valid/stall driver with bursts and gaps. Each accepted transaction is run
// through an in-bench interval set, and every result is checked field by
// field while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module angular_clip_range_set_tb;
  import acrs_pkg::*;

  localparam int FULL = 1 << ANGLE_BITS;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  acrs_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  acrs_out_t out_data_o;

  angular_clip_range_set u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // shadow interval set
  logic [ANG_W-1:0] arc_lo [MAX_INTERVALS];
  logic [ANG_W-1:0] arc_hi [MAX_INTERVALS];
  int               arc_cnt = 0;
  logic             ovf_flag = 1'b0;

  acrs_in_t  range_cmds [$];
  acrs_out_t coverage_replies [$];
  acrs_out_t want;
  int        mismatch_cnt = 0;
  int        n_cmds = 0;
  logic      in_fire = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        rx_cycle = 0;
  int        stall_style = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  function automatic void arc_insert_at(input int pos, input logic [ANG_W-1:0] lo,
                                        input logic [ANG_W-1:0] hi);
    int j;
    if (arc_cnt >= MAX_INTERVALS || pos > arc_cnt) begin
      ovf_flag = 1'b1;
      return;
    end
    for (j = arc_cnt; j > pos; j--) begin
      arc_lo[j] = arc_lo[j-1];
      arc_hi[j] = arc_hi[j-1];
    end
    arc_lo[pos] = lo;
    arc_hi[pos] = hi;
    arc_cnt++;
  endfunction

  function automatic void arc_remove_at(input int pos);
    int j;
    if (pos >= arc_cnt) return;
    for (j = pos; j + 1 < arc_cnt; j++) begin
      arc_lo[j] = arc_lo[j+1];
      arc_hi[j] = arc_hi[j+1];
    end
    arc_cnt--;
  endfunction

  function automatic void arc_add(input logic [ANG_W-1:0] lo, input logic [ANG_W-1:0] hi);
    int i;
    for (i = 0; i < arc_cnt; i++) begin
      if (arc_hi[i] < lo) continue;
      if (hi < arc_lo[i]) begin
        arc_insert_at(i, lo, hi);
        return;
      end
      if (arc_lo[i] <= lo && arc_hi[i] >= hi) return;
      if (lo < arc_lo[i]) arc_lo[i] = lo;
      if (hi <= arc_hi[i]) return;
      while (i + 1 < arc_cnt && arc_lo[i+1] <= hi) begin
        arc_hi[i] = arc_hi[i+1];
        arc_remove_at(i + 1);
      end
      if (hi > arc_hi[i]) arc_hi[i] = hi;
      return;
    end
    arc_insert_at(arc_cnt, lo, hi);
  endfunction

  function automatic logic arc_visible(input logic [ANG_W-1:0] lo,
                                       input logic [ANG_W-1:0] hi);
    int i;
    for (i = 0; i < arc_cnt; i++) begin
      if (lo >= arc_lo[i] && hi <= arc_hi[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic acrs_out_t predict_clip_reply(input acrs_in_t cmd);
    acrs_out_t        r;
    logic [ANG_W-1:0] a;
    logic [ANG_W-1:0] b;
    a = (cmd.from_angle > FULL_ANGLE) ? FULL_ANGLE : cmd.from_angle;
    b = (cmd.to_angle > FULL_ANGLE) ? FULL_ANGLE : cmd.to_angle;
    r.visible = 1'b1;
    case (cmd.mode)
      MODE_ADD: begin
        if (a > b) begin
          arc_add('0, b);
          arc_add(a, FULL_ANGLE);
        end else begin
          arc_add(a, b);
        end
      end
      MODE_QUERY: begin
        if (a > b) r.visible = arc_visible('0, b) || arc_visible(a, FULL_ANGLE);
        else r.visible = arc_visible(a, b);
      end
      MODE_CLEAR: arc_cnt = 0;
      default: ;
    endcase
    r.full_res = (arc_cnt > 0 && arc_lo[0] == '0 && arc_hi[0] == FULL_ANGLE);
    r.overflow = ovf_flag;
    r.interval_count = OUT_CNT_W'(arc_cnt);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic push_cmd(input logic [1:0] m, input int f, input int t);
    acrs_in_t c;
    c.mode = m;
    c.from_angle = ANG_W'(f);
    c.to_angle = ANG_W'(t);
    range_cmds.push_back(c);
    if (m != MODE_NONE) n_cmds++;
  endtask

  task automatic push_inner_query(input int lo, input int hi);
    int q_lo;
    int q_hi;
    q_lo = lo + $urandom_range(0, hi - lo);
    q_hi = q_lo + $urandom_range(0, hi - q_lo);
    push_cmd(MODE_QUERY, q_lo, q_hi);
  endtask

  // driver: one transaction offered at a time, held until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (range_cmds.size() > 0) begin
          in_valid_i <= 1'b1;
          in_data_i <= range_cmds.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle % 200 == 0) stall_style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!hold_done && range_cmds.size() < 600) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_style)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= 1'($urandom_range(0, 1));
          2: out_stall_i <= (rx_cycle % 3 == 0);
          default: out_stall_i <= ($urandom_range(0, 99) < 85);
        endcase
      end
    end
  end

  // monitor: results checked first, then accepted commands predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (coverage_replies.size() == 0) begin
          report_mismatch("result with no transaction pending");
        end else begin
          want = coverage_replies.pop_front();
          if (out_data_o.visible !== want.visible)
            report_mismatch($sformatf("visible got %b exp %b",
                                      out_data_o.visible, want.visible));
          if (out_data_o.full_res !== want.full_res)
            report_mismatch($sformatf("full_res got %b exp %b",
                                      out_data_o.full_res, want.full_res));
          if (out_data_o.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %b exp %b",
                                      out_data_o.overflow, want.overflow));
          if (out_data_o.interval_count !== want.interval_count)
            report_mismatch($sformatf("interval_count got %0d exp %0d",
                                      out_data_o.interval_count, want.interval_count));
        end
      end
      if (in_valid_i && !in_stall_o) coverage_replies.push_back(predict_clip_reply(in_data_i));
      in_fire <= in_valid_i && !in_stall_o;
    end
  end

  initial begin
    int kind;
    int f;
    int t;
    int x;
    int r;
    // directed corners
    push_cmd(MODE_QUERY, 0, FULL);
    push_cmd(MODE_ADD, 100, 200);
    push_cmd(MODE_QUERY, 120, 180);
    push_cmd(MODE_QUERY, 50, 150);
    push_cmd(MODE_ADD, 200, 300);
    push_cmd(MODE_ADD, 400, 400);
    push_cmd(MODE_QUERY, 400, 400);
    push_cmd(MODE_ADD, 350, 450);
    push_cmd(MODE_ADD, 0, 1000);
    push_cmd(MODE_ADD, 17'h1FFFF, 5);
    push_cmd(MODE_QUERY, 17'h1FFFF, 10);
    push_cmd(MODE_NONE, 17'h0AAAA, 17'h15555);
    push_cmd(MODE_ADD, 60000, 2000);
    push_cmd(MODE_QUERY, 61000, 1500);
    push_cmd(MODE_ADD, 0, 17'h1FFFF);
    push_cmd(MODE_QUERY, 0, FULL);
    push_cmd(MODE_CLEAR, 17'h15555, 17'h0AAAA);
    push_cmd(MODE_ADD, FULL, 0);
    push_cmd(MODE_QUERY, 17'h1FFFF, 17'h1FFFF);
    push_cmd(MODE_QUERY, 0, 0);
    push_cmd(MODE_ADD, 17'h15555, 17'h0AAAA);
    push_cmd(MODE_QUERY, 100, 100);
    push_cmd(MODE_CLEAR, 0, 0);
    // random episodes
    while (n_cmds < 1050) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2: begin
          push_cmd(MODE_CLEAR, $urandom_range(0, FULL), $urandom_range(0, FULL));
          repeat ($urandom_range(40, 80)) begin
            f = $urandom_range(0, FULL);
            t = f + $urandom_range(0, 150);
            if (t > FULL && $urandom_range(0, 1)) t = $urandom_range(FULL + 1, 17'h1FFFF);
            push_cmd(MODE_ADD, f, t);
            if ($urandom_range(0, 3) == 0) push_inner_query(f, (t > FULL) ? FULL : t);
          end
        end
        3, 4, 5: begin
          if ($urandom_range(0, 1)) push_cmd(MODE_CLEAR, 0, FULL);
          f = 0;
          t = 0;
          repeat ($urandom_range(10, 30)) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
              push_cmd(MODE_ADD, $urandom_range(30000, FULL), $urandom_range(0, 29999));
            end else if (r < 5) begin
              f = $urandom_range(0, FULL);
              t = f + $urandom_range(0, 6000);
              if (t > FULL) t = FULL;
              push_cmd(MODE_ADD, f, t);
            end else if (r < 8) begin
              push_inner_query(f, t);
            end else begin
              push_cmd(MODE_QUERY, $urandom_range(0, FULL), $urandom_range(0, FULL));
            end
          end
        end
        6: begin
          push_cmd(MODE_CLEAR, 0, 0);
          x = $urandom_range(0, FULL);
          push_cmd(MODE_ADD, 0, x);
          push_cmd(MODE_QUERY, 0, FULL);
          push_cmd(MODE_ADD, $urandom_range(0, x), FULL);
          push_cmd(MODE_QUERY, $urandom_range(0, FULL), $urandom_range(0, FULL));
          push_cmd(MODE_QUERY, 0, FULL);
          push_cmd(MODE_ADD, $urandom_range(0, FULL), $urandom_range(0, FULL));
          push_cmd(MODE_QUERY, $urandom_range(0, FULL), $urandom_range(0, FULL));
        end
        7: begin
          repeat ($urandom_range(5, 20))
            push_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 17'h1FFFF),
                     $urandom_range(0, 17'h1FFFF));
        end
        default: begin
          repeat ($urandom_range(5, 15))
            push_cmd(MODE_QUERY, $urandom_range(0, FULL), $urandom_range(0, FULL));
        end
      endcase
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (range_cmds.size() == 0 && !in_valid_i && coverage_replies.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0 && coverage_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #7200000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
